[sv/pprk2_pkg.sv]
// Shared constants, types and the arctangent table for the planar pose RK2 integrator.
// Used by pprk2_mul, pprk2_cordic and planar_pose_rk2_integrator_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pprk2_pkg;

    // Field widths of the stream payloads.
    localparam int VEL_W      = 32;
    localparam int ANG_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int OUT_POSE_W = 48;
    localparam int IN_DATA_W  = 3 * VEL_W + STAMP_W;
    localparam int OUT_DATA_W = 2 * OUT_POSE_W + ANG_W;

    // Position accumulator width; accumulators wrap at this width.
    localparam int POS_W = 48;

    // Fixed-point scaling.
    localparam int FRAC_SHIFT = 16;
    localparam int TRIG_FRAC  = 30;
    localparam int DMAG_W     = 48;

    // Shared digit-serial multiplier.
    localparam int MUL_A_W    = 48;
    localparam int MUL_B_W    = 32;
    localparam int DIG_W      = 4;
    localparam int MUL_DIGITS = MUL_B_W / DIG_W;
    localparam int MCNT_W     = $clog2(MUL_DIGITS);
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int RND_W      = PROD_W - TRIG_FRAC;

    // CORDIC.
    localparam int TRIG_W       = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int ATAN_LEN     = 30;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CIDX_W       = $clog2(CORDIC_N);
    localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_W,
        ST_DIR,
        ST_MUL_X,
        ST_MUL_Y,
        ST_WAIT_TRIG,
        ST_MUL_XC,
        ST_MUL_YS,
        ST_MUL_XS,
        ST_MUL_YC,
        ST_UPD,
        ST_DONE
    } t_state;

    // Cosine and sine as sign and magnitude, Q2.30.
    typedef struct packed {
        logic              c_neg;
        logic [TRIG_W-1:0] c_mag;
        logic              s_neg;
        logic [TRIG_W-1:0] s_mag;
    } t_trig;

    // Rounded arctangent of 2^-i in binary-angle units (full circle = 2^32).
    function automatic logic [ANG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/pprk2_mul.sv]
// Digit-serial unsigned multiplier: the multiplier operand is shifted out one digit per cycle.
// Depends on pprk2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pprk2_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pprk2_pkg::MUL_A_W-1:0]    i_a,
    input  logic [pprk2_pkg::MUL_B_W-1:0]    i_b,
    output logic                             o_done,
    output logic [pprk2_pkg::PROD_W-1:0]     o_prod
);
    import pprk2_pkg::*;

    localparam int SUM_W = MUL_A_W + DIG_W;

    logic               r_busy;
    logic               r_done;
    logic [MCNT_W-1:0]  r_cnt;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_A_W-1:0] r_hi;
    logic [MUL_B_W-1:0] r_lo;
    logic [SUM_W-1:0]   part;
    logic [SUM_W-1:0]   sum;

    assign part = SUM_W'(r_a) * SUM_W'(r_b[DIG_W-1:0]);
    assign sum  = SUM_W'(r_hi) + part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MCNT_W'(MUL_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The partial sum shifts right one digit per cycle; its low digit drops into r_lo.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_hi <= sum[SUM_W-1:DIG_W];
            r_lo <= {sum[DIG_W-1:0], r_lo[MUL_B_W-1:DIG_W]};
            r_b  <= r_b >> DIG_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule

`default_nettype wire

[sv/pprk2_cordic.sv]
// Iterative CORDIC, one rotation step per cycle, giving cosine and sine of a binary angle.
// Depends on pprk2_pkg (table, widths, t_trig).
`timescale 1ns / 1ps
`default_nettype none

module pprk2_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pprk2_pkg::ANG_W-1:0]   i_angle,
    output logic                          o_busy,
    output pprk2_pkg::t_trig              o_trig
);
    import pprk2_pkg::*;

    logic                     r_busy;
    logic [CIDX_W-1:0]        r_i;
    logic                     r_flip;
    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [ANG_W-1:0]  r_z;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [ANG_W-1:0]  at;
    logic                     flip;

    // Angles in the second and third quadrant are turned by half a circle.
    assign flip = i_angle[ANG_W-1] ^ i_angle[ANG_W-2];
    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign at   = signed'(atan_turn(ATAN_IDX_W'(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            if (r_i == CIDX_W'(CORDIC_N - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= signed'({i_angle[ANG_W-1] ^ flip, i_angle[ANG_W-2:0]});
        end else if (r_busy) begin
            if (!r_z[ANG_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_trig.c_neg = r_flip ^ r_x[TRIG_W-1];
    assign o_trig.c_mag = r_x[TRIG_W-1] ? (~r_x + 1'b1) : r_x;
    assign o_trig.s_neg = r_flip ^ r_y[TRIG_W-1];
    assign o_trig.s_mag = r_y[TRIG_W-1] ? (~r_y + 1'b1) : r_y;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i <= CIDX_W'(CORDIC_N - 1)))
        else $error("CORDIC step index past last step");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("CORDIC restarted while busy");

endmodule

`default_nettype wire

[sv/planar_pose_rk2_integrator_core.sv]
// Top level of the planar pose RK2 integrator: sequencer, pose accumulators and stream ports.
// Depends on pprk2_pkg, pprk2_mul and pprk2_cordic.
//
// Channel   Direction  Handshake                          Contents
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tuser = action, tdata = velocities, stamp
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata = pose x, pose y, heading
//
// An integrate transaction makes seven passes through the shared multiplier, which consumes
// one 4-bit digit per cycle, with the 20-step CORDIC running beside the two velocity products.
// A reset transaction goes straight to the done state, which loads the result register once it is free.
// The core is ready for the next transaction as soon as the result is in the output register,
// even while that result still waits for i_m_axis_tready.
// i_rst_n is synchronous and active low; it clears the pose and the stored stamp.
`timescale 1ns / 1ps
`default_nettype none

module planar_pose_rk2_integrator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // vel_body_x, vel_body_y, yaw_rate, stamp (32 bits each, from the lowest bit up)
    input  logic [pprk2_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // action
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // pose_x (48), pose_y (48), pose_heading (32), from the lowest bit up
    output logic [pprk2_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import pprk2_pkg::*;

    t_state               r_state;
    t_state               n_state;

    logic [VEL_W-1:0]     vx;
    logic [VEL_W-1:0]     vy;
    logic [VEL_W-1:0]     wz;
    logic [STAMP_W-1:0]   stamp;
    logic                 in_acc;

    logic [VEL_W-1:0]     r_vx_mag;
    logic [VEL_W-1:0]     r_vy_mag;
    logic [VEL_W-1:0]     r_w_mag;
    logic                 r_vx_neg;
    logic                 r_vy_neg;
    logic                 r_w_neg;
    logic [STAMP_W-1:0]   r_dt;
    logic [STAMP_W-1:0]   r_last_stamp;
    logic [ANG_W:0]       r_dang;
    logic [ANG_W:0]       n_dang;
    logic [DMAG_W-1:0]    r_dxm;
    logic [DMAG_W-1:0]    r_dym;

    logic [POS_W-1:0]     r_acc_x;
    logic [POS_W-1:0]     r_acc_y;
    logic [ANG_W-1:0]     r_acc_hd;

    logic [POS_W-1:0]     r_term;
    logic                 r_term_neg;
    logic                 r_term_to_y;
    logic                 r_term_vld;
    logic                 n_term_neg;
    logic [RND_W-1:0]     rnd;
    logic [POS_W-1:0]     addend;

    logic                 r_out_valid;
    logic [OUT_POSE_W-1:0] r_out_x;
    logic [OUT_POSE_W-1:0] r_out_y;
    logic [ANG_W-1:0]     r_out_hd;

    logic                 mul_start;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_done;
    logic [PROD_W-1:0]    mul_prod;

    logic                 cordic_start;
    logic [ANG_W-1:0]     cordic_angle;
    logic                 cordic_busy;
    t_trig                trig;

    assign vx    = i_s_axis_tdata[VEL_W-1:0];
    assign vy    = i_s_axis_tdata[2*VEL_W-1:VEL_W];
    assign wz    = i_s_axis_tdata[3*VEL_W-1:2*VEL_W];
    assign stamp = i_s_axis_tdata[3*VEL_W+STAMP_W-1:3*VEL_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    pprk2_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Direction for the rotation: heading plus half the angle delta.
    assign cordic_start = (r_state == ST_DIR);
    assign cordic_angle = r_acc_hd + r_dang[ANG_W:1];

    pprk2_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (cordic_angle),
        .o_busy  (cordic_busy),
        .o_trig  (trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_s_axis_tuser ? ST_DONE : ST_PREP;
                end
            end
            ST_PREP:      n_state = ST_MUL_W;
            ST_MUL_W:     if (mul_done) n_state = ST_DIR;
            ST_DIR:       n_state = ST_MUL_X;
            ST_MUL_X:     if (mul_done) n_state = ST_MUL_Y;
            ST_MUL_Y:     if (mul_done) n_state = ST_WAIT_TRIG;
            ST_WAIT_TRIG: if (!cordic_busy) n_state = ST_MUL_XC;
            ST_MUL_XC:    if (mul_done) n_state = ST_MUL_YS;
            ST_MUL_YS:    if (mul_done) n_state = ST_MUL_XS;
            ST_MUL_XS:    if (mul_done) n_state = ST_MUL_YC;
            ST_MUL_YC:    if (mul_done) n_state = ST_UPD;
            ST_UPD:       n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // A multiply is launched on entry to each multiply state, with that state's operands.
    always_comb begin
        mul_start = (n_state != r_state) &&
                    (n_state inside {ST_MUL_W, ST_MUL_X, ST_MUL_Y,
                                     ST_MUL_XC, ST_MUL_YS, ST_MUL_XS, ST_MUL_YC});
        case (n_state)
            ST_MUL_W: begin
                mul_a = MUL_A_W'(r_w_mag);
                mul_b = MUL_B_W'(r_dt);
            end
            ST_MUL_X: begin
                mul_a = MUL_A_W'(r_vx_mag);
                mul_b = MUL_B_W'(r_dt);
            end
            ST_MUL_Y: begin
                mul_a = MUL_A_W'(r_vy_mag);
                mul_b = MUL_B_W'(r_dt);
            end
            ST_MUL_XC: begin
                mul_a = MUL_A_W'(r_dxm);
                mul_b = MUL_B_W'(trig.c_mag);
            end
            ST_MUL_YS: begin
                mul_a = MUL_A_W'(r_dym);
                mul_b = MUL_B_W'(trig.s_mag);
            end
            ST_MUL_XS: begin
                mul_a = MUL_A_W'(r_dxm);
                mul_b = MUL_B_W'(trig.s_mag);
            end
            ST_MUL_YC: begin
                mul_a = MUL_A_W'(r_dym);
                mul_b = MUL_B_W'(trig.c_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Signed angle delta, kept to 33 bits for the heading step and its half.
    assign n_dang = r_w_neg ? (~mul_prod[ANG_W:0] + 1'b1) : mul_prod[ANG_W:0];

    // Rounding to Q.16 half away from zero is applied to the magnitude.
    assign rnd = mul_prod[PROD_W-1:TRIG_FRAC] + RND_W'(mul_prod[TRIG_FRAC-1]);

    always_comb begin
        case (r_state)
            ST_MUL_XC: n_term_neg = r_vx_neg ^ trig.c_neg;
            ST_MUL_YS: n_term_neg = ~(r_vy_neg ^ trig.s_neg);
            ST_MUL_XS: n_term_neg = r_vx_neg ^ trig.s_neg;
            ST_MUL_YC: n_term_neg = r_vy_neg ^ trig.c_neg;
            default:   n_term_neg = 1'b0;
        endcase
    end

    assign addend = r_term_neg ? ~r_term : r_term;

    // Operand, product and output capture.
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_s_axis_tuser) begin
            r_vx_neg <= vx[VEL_W-1];
            r_vy_neg <= vy[VEL_W-1];
            r_w_neg  <= wz[VEL_W-1];
            r_vx_mag <= vx[VEL_W-1] ? (~vx + 1'b1) : vx;
            r_vy_mag <= vy[VEL_W-1] ? (~vy + 1'b1) : vy;
            r_w_mag  <= wz[VEL_W-1] ? (~wz + 1'b1) : wz;
            r_dt     <= stamp - r_last_stamp;
        end
        if (mul_done) begin
            case (r_state)
                ST_MUL_W: r_dang <= n_dang;
                ST_MUL_X: r_dxm  <= mul_prod[FRAC_SHIFT +: DMAG_W];
                ST_MUL_Y: r_dym  <= mul_prod[FRAC_SHIFT +: DMAG_W];
                ST_MUL_XC, ST_MUL_YS, ST_MUL_XS, ST_MUL_YC: begin
                    r_term      <= POS_W'(rnd);
                    r_term_neg  <= n_term_neg;
                    r_term_to_y <= (r_state == ST_MUL_XS) || (r_state == ST_MUL_YC);
                end
                default: ;
            endcase
        end
        if (r_state == ST_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_x  <= OUT_POSE_W'(r_acc_x);
            r_out_y  <= OUT_POSE_W'(r_acc_y);
            r_out_hd <= r_acc_hd;
        end
    end

    // Pose state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_hd     <= '0;
            r_last_stamp <= '0;
            r_term_vld   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_term_vld <= mul_done && (r_state inside {ST_MUL_XC, ST_MUL_YS,
                                                       ST_MUL_XS, ST_MUL_YC});
            if (in_acc) begin
                if (i_s_axis_tuser) begin
                    r_acc_x  <= '0;
                    r_acc_y  <= '0;
                    r_acc_hd <= '0;
                end else begin
                    r_last_stamp <= stamp;
                end
            end
            // Each rotated term is registered after rounding and lands in its accumulator in the next cycle.
            if (r_term_vld) begin
                if (r_term_to_y) begin
                    r_acc_y <= r_acc_y + addend + POS_W'(r_term_neg);
                end else begin
                    r_acc_x <= r_acc_x + addend + POS_W'(r_term_neg);
                end
            end
            if (r_state == ST_UPD) begin
                r_acc_hd <= r_acc_hd + r_dang[ANG_W-1:0];
            end
            if (r_state == ST_DONE && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_hd, r_out_y, r_out_x};

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tuser) |=> (r_acc_x == '0 && r_acc_y == '0 && r_acc_hd == '0))
        else $error("reset transaction did not clear the pose");

    a_idle_trig_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !cordic_busy)
        else $error("CORDIC still running while idle");

    a_term_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term_vld |-> (r_state == ST_MUL_YS || r_state == ST_MUL_XS ||
                        r_state == ST_MUL_YC || r_state == ST_UPD))
        else $error("rotated term pending outside the rotation sequence");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for planar_pose_rk2_integrator_core: drives odometry updates and
// pose resets on the input stream and checks every pose against an in-bench RK2/CORDIC tracker.
// Depends on pprk2_pkg (port widths) and the core RTL.

module tb;

    localparam int CORDIC_ITERS     = 20;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 100;

    typedef enum logic {
        ACT_INTEGRATE  = 1'b0,
        ACT_RESET_POSE = 1'b1
    } t_odom_action;

    typedef struct packed {
        t_odom_action action;
        logic [31:0]  vel_x;
        logic [31:0]  vel_y;
        logic [31:0]  yaw_rate;
        logic [31:0]  stamp;
    } t_odom_item;

    typedef struct packed {
        logic [47:0] x;
        logic [47:0] y;
        logic [31:0] heading;
    } t_pose;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [pprk2_pkg::IN_DATA_W-1:0] i_s_axis_tdata = '0;
    logic                            i_s_axis_tuser = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [pprk2_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;

    planar_pose_rk2_integrator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Arctangent of 2^-i in binary-angle units, full circle = 2^32.
    longint atan_bam [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    // Tracked pose and stored stamp.
    logic [47:0] est_x = '0;
    logic [47:0] est_y = '0;
    logic [31:0] est_heading = '0;
    logic [31:0] est_stamp = '0;

    t_odom_item pending_items[$];
    t_pose      expected_poses[$];
    t_odom_item drv_item;
    logic       in_took = 1'b0;
    int         send_gap = 0;
    int         stall_left = 0;
    bit         no_gaps = 1'b0;
    bit         rx_long_hold = 1'b0;
    bit         rx_hold_taken = 1'b0;
    int         fail_count = 0;
    int         poses_checked = 0;
    int         items_sent = 0;
    int         resets_sent = 0;
    logic [31:0] plan_stamp = '0;

    function automatic logic [31:0] magnitude32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Cosine and sine of a binary angle in Q2.30; the angle is folded into
    // [-1/4, 1/4) turn first and the results negated to undo the fold.
    function automatic void bam_cos_sin(input logic [31:0] ang, output longint c,
                                        output longint s);
        logic        flip;
        logic [31:0] a;
        longint      x, y, z, xs, ys;
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'(signed'(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_bam[i];
            end else begin
                x += ys;
                y -= xs;
                z += atan_bam[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Signed-magnitude delta times a Q2.30 trig value, rounded half away from zero to Q.16.
    function automatic logic [63:0] scale_by_trig(input logic [63:0] dmag, input logic dneg,
                                                  input longint t);
        logic        tneg;
        logic [63:0] tmag, lo, hi, r;
        tneg = t < 0;
        tmag = tneg ? 64'(-t) : 64'(t);
        lo = {32'd0, dmag[31:0]} * tmag;
        hi = (dmag >> 32) * tmag;
        r = (hi << 2) + ((lo + 64'd536870912) >> 30);
        return (dneg != tneg) ? -r : r;
    endfunction

    // Advances the tracked pose by one transaction and returns the pose it reports.
    function automatic t_pose track_pose(input t_odom_item it);
        logic [31:0] dt;
        logic [63:0] dxm, dym, wprod, ax, ay;
        longint      c, s;
        t_pose       p;
        if (it.action == ACT_RESET_POSE) begin
            est_x = '0;
            est_y = '0;
            est_heading = '0;
        end else begin
            dt = it.stamp - est_stamp;
            dxm = ({32'd0, magnitude32(it.vel_x)} * {32'd0, dt}) >> 16;
            dym = ({32'd0, magnitude32(it.vel_y)} * {32'd0, dt}) >> 16;
            wprod = {32'd0, magnitude32(it.yaw_rate)} * {32'd0, dt};
            if (it.yaw_rate[31])
                wprod = -wprod;
            // Direction at the midpoint of the step: heading plus half the angle delta.
            bam_cos_sin(est_heading + wprod[32:1], c, s);
            ax = {16'd0, est_x} + scale_by_trig(dxm, it.vel_x[31], c)
                 - scale_by_trig(dym, it.vel_y[31], s);
            ay = {16'd0, est_y} + scale_by_trig(dxm, it.vel_x[31], s)
                 + scale_by_trig(dym, it.vel_y[31], c);
            est_x = ax[47:0];
            est_y = ay[47:0];
            est_heading = est_heading + wprod[31:0];
            est_stamp = it.stamp;
        end
        p.x = est_x;
        p.y = est_y;
        p.heading = est_heading;
        return p;
    endfunction

    function automatic logic [31:0] rand_rate();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 24);
    endfunction

    task automatic queue_item(input t_odom_action act, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [31:0] wz,
                              input logic [31:0] stamp);
        t_odom_item it;
        it.action = act;
        it.vel_x = vx;
        it.vel_y = vy;
        it.yaw_rate = wz;
        it.stamp = stamp;
        pending_items.insert(pending_items.size(), it);
        if (act == ACT_INTEGRATE)
            plan_stamp = stamp;
    endtask

    // Mostly plausible odometry: small forward steps of time and moderate rates,
    // mixed with resets, fully random items, repeated stamps and stamps going back.
    task automatic queue_random_items(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                queue_item(ACT_RESET_POSE, $urandom, $urandom, $urandom, $urandom);
            else if (r < 20)
                queue_item(ACT_INTEGRATE, $urandom, $urandom, $urandom, $urandom);
            else if (r < 25)
                queue_item(ACT_INTEGRATE, rand_rate(), rand_rate(), rand_rate(), plan_stamp);
            else if (r < 28)
                queue_item(ACT_INTEGRATE, rand_rate(), rand_rate(), rand_rate(),
                           plan_stamp - $urandom_range(1, 32'h0001_0000));
            else
                queue_item(ACT_INTEGRATE, rand_rate(), rand_rate(), rand_rate(),
                           plan_stamp + $urandom_range(0, 32'h0002_0000));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_s_axis_tvalid || expected_poses.size() != 0)
            @(posedge i_clk);
    endtask

    // Input side: one transaction at a time from the pending queue, random gaps between unless no_gaps.
    always @(negedge i_clk) begin : tx_side
        logic offer;
        offer = i_s_axis_tvalid;
        if (in_took) begin
            offer = 1'b0;
            if (no_gaps)
                send_gap = 0;
            else if ($urandom_range(0, 99) < 60)
                send_gap = 0;
            else if ($urandom_range(0, 99) < 80)
                send_gap = $urandom_range(1, 3);
            else
                send_gap = $urandom_range(10, 60);
        end
        if (!offer && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                drv_item = pending_items.pop_front();
                i_s_axis_tdata <= {drv_item.stamp, drv_item.yaw_rate, drv_item.vel_y,
                                   drv_item.vel_x};
                i_s_axis_tuser <= drv_item.action;
                offer = 1'b1;
            end
        end
        i_s_axis_tvalid <= offer;
    end

    // Output side back-pressure, including one long hold-off on request.
    always @(negedge i_clk) begin : rx_side
        int r;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_long_hold && !rx_hold_taken) begin
            rx_hold_taken = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (no_gaps) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 80);
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    // Checks output transactions first, then predicts for the input transaction of this edge.
    always @(posedge i_clk) begin : monitor
        t_pose got, want;
        logic  bad;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.x = o_m_axis_tdata[47:0];
                got.y = o_m_axis_tdata[95:48];
                got.heading = o_m_axis_tdata[127:96];
                if (expected_poses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb: unexpected pose x=%h y=%h hdg=%h", got.x, got.y,
                                 got.heading);
                end else begin
                    want = expected_poses.pop_front();
                    poses_checked++;
                    bad = (got.x !== want.x) || (got.y !== want.y)
                          || (got.heading !== want.heading);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("tb: pose mismatch, got x=%h y=%h hdg=%h, want x=%h y=%h hdg=%h",
                                     got.x, got.y, got.heading, want.x, want.y, want.heading);
                    end
                end
            end
            in_took <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_sent++;
                if (drv_item.action == ACT_RESET_POSE)
                    resets_sent++;
                expected_poses.insert(expected_poses.size(), track_pose(drv_item));
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Equal stamps, then unit moves that walk the heading through every quadrant.
        queue_item(ACT_INTEGRATE, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_item(ACT_INTEGRATE, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        queue_item(ACT_INTEGRATE, 32'h0, 32'h0001_0000, 32'h0000_4000, 32'h0002_0000);
        queue_item(ACT_INTEGRATE, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_4000, 32'h0003_0000);
        queue_item(ACT_INTEGRATE, 32'h0001_0000, 32'h0, 32'h0000_4000, 32'h0004_0000);
        queue_item(ACT_INTEGRATE, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000, 32'h0005_0000);
        // Odd angle products exercise the floor of the half delta, both signs.
        queue_item(ACT_INTEGRATE, 32'h0000_0100, 32'h0, 32'h0000_0001, 32'h0005_0003);
        queue_item(ACT_INTEGRATE, 32'h0000_0100, 32'h0, 32'hFFFF_FFFF, 32'h0005_0006);
        // Field extremes, smallest step, then the largest step (stamp one below the last).
        queue_item(ACT_INTEGRATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, plan_stamp + 1);
        queue_item(ACT_INTEGRATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, plan_stamp - 1);
        queue_item(ACT_INTEGRATE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, plan_stamp);
        queue_item(ACT_RESET_POSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(ACT_INTEGRATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678,
                   plan_stamp + 32'h8000_0000);
        queue_item(ACT_INTEGRATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   plan_stamp + 32'h8000_0000);
        queue_item(ACT_RESET_POSE, 32'h0, 32'h0, 32'h0, 32'h0);
        // Stamp going back, then a forward wrap through zero.
        queue_item(ACT_INTEGRATE, 32'h0002_0000, 32'h0, 32'h0000_1000, 32'hFFFF_8000);
        queue_item(ACT_INTEGRATE, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_1000, 32'h0000_8000);
        queue_item(ACT_INTEGRATE, 32'h0001_0000, 32'h0, 32'hFFFF_C000, plan_stamp + 32'h0001_0000);
        queue_item(ACT_INTEGRATE, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                   plan_stamp + 32'h0001_0000);
        queue_item(ACT_INTEGRATE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_2AAA,
                   plan_stamp + 32'h0000_FFFF);
        wait_drained();

        no_gaps = 1'b1;
        queue_random_items(150);
        wait_drained();
        no_gaps = 1'b0;

        queue_random_items(400);
        while (pending_items.size() > 300)
            @(posedge i_clk);
        // The receiver holds off while the sender keeps offering, so the core backs up.
        rx_long_hold = 1'b1;
        queue_random_items(250);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb: %0d transactions sent, %0d of them pose resets; %0d poses checked",
                 items_sent, resets_sent, poses_checked);
        $display("tb: included a %0d-cycle output hold-off and gap-free streaming",
                 LONG_HOLD_CYCLES);
        if (fail_count == 0 && expected_poses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("tb: timed out with %0d poses outstanding", expected_poses.size());
        $display("tb: failure");
        $finish;
    end

endmodule
